[rtl/core/cdq_pkg.sv]
`default_nettype none
package cdq_pkg;

   localparam int DEPTH = 64;
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CAP_W = 7;
   localparam int EFF_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int WORD_W = 32;
   localparam int OP_W = 3;
   localparam int REQ_W = 40;
   localparam int RSP_W = 40;
   localparam int ADDR_W = 3;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
   localparam logic [WORD_W-1:0] PEEK_FAIL = '1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } op_type;

   typedef enum logic [0:0] {
      REG_CAPACITY = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic clear;
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } cell_cmd_type;

endpackage
`default_nettype wire

[rtl/core/cdq_cell.sv]
`default_nettype none
module cdq_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  cdq_pkg::cell_cmd_type        cmd,
   input  wire  [cdq_pkg::WORD_W-1:0]   value,
   input  wire                          left_valid,
   input  wire  [cdq_pkg::WORD_W-1:0]   left_data,
   input  wire                          right_valid,
   input  wire  [cdq_pkg::WORD_W-1:0]   right_data,
   output logic                         valid_out,
   output logic [cdq_pkg::WORD_W-1:0]   data_out,
   output logic                         last_out
);
   import cdq_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.push_front) begin
         valid_in = left_valid;
         data_in  = left_data;
      end else if (cmd.push_back) begin
         if (!valid_ff && left_valid) begin
            valid_in = 1'b1;
            data_in  = value;
         end
      end else if (cmd.pop_front) begin
         valid_in = right_valid;
         data_in  = right_data;
      end else if (cmd.pop_back) begin
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
   assign last_out  = valid_ff && !right_valid;

endmodule
`default_nettype wire

[rtl/core/cdq_cell_row.sv]
`default_nettype none
module cdq_cell_row (
   input  wire                          clock,
   input  wire                          reset,
   input  cdq_pkg::cell_cmd_type        cmd,
   input  wire  [cdq_pkg::WORD_W-1:0]   value,
   output logic [cdq_pkg::WORD_W-1:0]   front_data,
   output logic [cdq_pkg::WORD_W-1:0]   back_data
);
   import cdq_pkg::*;

   logic              valid_w [DEPTH];
   logic [WORD_W-1:0] data_w  [DEPTH];
   logic              last_w  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic              lv;
      logic [WORD_W-1:0] ld;
      logic              rv;
      logic [WORD_W-1:0] rd;

      if (i == 0) begin : g_head
         assign lv = 1'b1;
         assign ld = value;
      end else begin : g_mid
         assign lv = valid_w[i-1];
         assign ld = data_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign rv = 1'b0;
         assign rd = '0;
      end else begin : g_body
         assign rv = valid_w[i+1];
         assign rd = data_w[i+1];
      end

      cdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .value       (value),
         .left_valid  (lv),
         .left_data   (ld),
         .right_valid (rv),
         .right_data  (rd),
         .valid_out   (valid_w[i]),
         .data_out    (data_w[i]),
         .last_out    (last_w[i])
      );
   end

   always_comb begin
      back_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_data = back_data | ({WORD_W{last_w[i]}} & data_w[i]);
      end
   end

   assign front_data = data_w[0];

endmodule
`default_nettype wire

[rtl/core/circular_deque_controller.sv]
`default_nettype none
// Channel   Direction  Handshake          Contents
// req_      in         tvalid/tready      operation, value
// rsp_      out        tvalid/tready      ok, data, empty_res, full_res
// csr_      in         APB, pready high   capacity at byte address 0
//
// Each accepted word yields one result word in the cycle after it is taken; a new word is
// taken every cycle while the result register is empty or being drained.
// The entries live in a row of cells that shift together toward either end.
// Reset empties the deque and sets the capacity to 64.
// A stalled result holds the request side until it is taken.
module circular_deque_controller (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [cdq_pkg::REQ_W-1:0]    req_tdata,   // operation[2:0], value[34:3]
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [cdq_pkg::RSP_W-1:0]    rsp_tdata,   // ok[0], data[32:1], empty_res[33], full_res[34]
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [cdq_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire  [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import cdq_pkg::*;

   logic [CAP_W-1:0]  cap_ff;
   logic [CAP_W-1:0]  cap_in;
   logic [OCC_W-1:0]  occ_ff;
   logic [OCC_W-1:0]  occ_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              ok_ff;
   logic              ok_in;
   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;
   logic              empty_ff;
   logic              empty_in;
   logic              full_ff;
   logic              full_in;

   logic              fire;
   logic              cap_write;
   logic [OP_W-1:0]   op;
   logic [WORD_W-1:0] value;
   logic [EFF_W-1:0]  eff_cap;
   logic              empty_now;
   logic              full_now;
   logic [WORD_W-1:0] front_data;
   logic [WORD_W-1:0] back_data;
   cell_cmd_type      cmd;

   assign csr_pready = 1'b1;
   assign cap_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_ff} : '0;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign op         = req_tdata[OP_W-1:0];
   assign value      = req_tdata[OP_W +: WORD_W];

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = EFF_W'(1);
      end else if (EFF_W'(cap_ff) > EFF_W'(DEPTH)) begin
         eff_cap = EFF_W'(DEPTH);
      end else begin
         eff_cap = EFF_W'(cap_ff);
      end
   end

   assign empty_now = (occ_ff == '0);
   assign full_now  = (EFF_W'(occ_ff) >= eff_cap);

   always_comb begin
      cmd        = '0;
      cmd.clear  = cap_write;
      occ_in     = occ_ff;
      ok_in      = 1'b0;
      data_in    = '0;
      if (fire) begin
         case (op)
            OP_PUSH_FRONT: begin
               if (!full_now) begin
                  cmd.push_front = 1'b1;
                  occ_in         = occ_ff + OCC_W'(1);
                  ok_in          = 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (!full_now) begin
                  cmd.push_back = 1'b1;
                  occ_in        = occ_ff + OCC_W'(1);
                  ok_in         = 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (!empty_now) begin
                  cmd.pop_front = 1'b1;
                  occ_in        = occ_ff - OCC_W'(1);
                  ok_in         = 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (!empty_now) begin
                  cmd.pop_back = 1'b1;
                  occ_in       = occ_ff - OCC_W'(1);
                  ok_in        = 1'b1;
               end
            end
            OP_PEEK_FRONT: begin
               if (!empty_now) begin
                  data_in = front_data;
                  ok_in   = 1'b1;
               end else begin
                  data_in = PEEK_FAIL;
               end
            end
            OP_PEEK_BACK: begin
               if (!empty_now) begin
                  data_in = back_data;
                  ok_in   = 1'b1;
               end else begin
                  data_in = PEEK_FAIL;
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
      if (cap_write) begin
         occ_in = '0;
      end
   end

   assign cap_in       = cap_write ? csr_pwdata[CAP_W-1:0] : cap_ff;
   assign empty_in     = (occ_in == '0);
   assign full_in      = (EFF_W'(occ_in) >= eff_cap);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         ok_ff    <= ok_in;
         data_ff  <= data_in;
         empty_ff <= empty_in;
         full_ff  <= full_in;
      end
   end

   cdq_cell_row u_row (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .value      (value),
      .front_data (front_data),
      .back_data  (back_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-WORD_W-3){1'b0}}, full_ff, empty_ff, data_ff, ok_ff};

endmodule
`default_nettype wire
